>>> design/rvc_pkg.sv
package rvc_pkg;

    // Default data memory size in bytes
    localparam int unsigned DMEM_BYTES_DEF = 1024;

    // Item actions
    localparam logic [1:0] ACT_EXEC    = 2'd0;
    localparam logic [1:0] ACT_PRELOAD = 2'd1;
    localparam logic [1:0] ACT_READ    = 2'd2;

    // Halt causes
    localparam logic [1:0] CAUSE_NONE      = 2'd0;
    localparam logic [1:0] CAUSE_HALT_WORD = 2'd1;
    localparam logic [1:0] CAUSE_OPCODE    = 2'd2;
    localparam logic [1:0] CAUSE_R_FUNCT3  = 2'd3;

    localparam logic [31:0] HALT_WORD = 32'hFFFF_FFFF;

    // Major opcodes
    localparam logic [6:0] OP_R      = 7'h33;
    localparam logic [6:0] OP_I      = 7'h13;
    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_JAL    = 7'h6F;

    // funct3 / funct7 codes
    localparam logic [2:0] F3_ADD = 3'd0;
    localparam logic [2:0] F3_XOR = 3'd4;
    localparam logic [2:0] F3_OR  = 3'd6;
    localparam logic [2:0] F3_AND = 3'd7;
    localparam logic [2:0] F3_BEQ = 3'd0;
    localparam logic [2:0] F3_BNE = 3'd1;
    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] instruction;
        logic [9:0]  mem_address;
        logic [31:0] mem_word;
    } in_item_t;

    typedef struct packed {
        logic [31:0] next_pc;
        logic        is_halted;
        logic [1:0]  halt_cause;
        logic        reg_write_enable;
        logic [4:0]  reg_write_index;
        logic [31:0] reg_write_value;
        logic [31:0] read_word;
    } out_item_t;

    // Register file write port
    typedef struct packed {
        logic        en;
        logic [4:0]  addr;
        logic [31:0] data;
    } rf_wr_t;

    // Data memory word request and response
    typedef struct packed {
        logic        valid;
        logic        write;
        logic [31:0] addr;
        logic [31:0] wdata;
    } dmem_req_t;

    typedef struct packed {
        logic        ready;
        logic        done;
        logic        clearing;
        logic [31:0] rdata;
    } dmem_rsp_t;

endpackage

>>> design/rv32i_subset_single_cycle_core.sv
// RV32I subset core (ADD/SUB/AND/OR/XOR, ADDI/ANDI/ORI/XORI, LW, SW, BEQ/BNE, JAL) that runs
// one pre-fetched instruction per input transfer and returns one result transfer for each,
// in order; two further actions preload and read back a big-endian data memory word. After
// reset the data memory is swept to zero, one byte a cycle, and no input transfer is taken
// in that time. The register file is a 32-entry synchronous memory read as the item is
// taken, with a write-first bypass so that each instruction sees the result of the one
// before it. ALU, immediate, branch, jump and halt items stream back to back while the
// result side keeps up. Loads, stores, preloads and readbacks go through the single
// byte-wide data memory port, one byte per cycle once the address is reduced modulo
// DMEM_BYTES, by masking when DMEM_BYTES is a power of two and otherwise one hex digit
// a cycle.
module rv32i_subset_single_cycle_core
    import rvc_pkg::*;
#(
    parameter int unsigned DMEM_BYTES = DMEM_BYTES_DEF
)
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    // Execute slot: the item whose register operands sit in the register file read registers
    logic        dec_valid_reg;
    in_item_t    dec_item_reg;
    logic        mem_issued_reg;
    logic        mem_fin_reg;
    logic [31:0] mem_rdata_reg;

    // Architectural state kept in flops
    logic [31:0] pc_reg;
    logic        halt_reg;

    // Result register
    logic        out_valid_reg;
    out_item_t   out_item_reg;

    logic        accept;
    logic        out_free;
    logic        ex_done;
    logic        ex_is_mem;
    logic        mem_ok;
    logic [31:0] mem_load_word;

    logic [31:0] rs1_data;
    logic [31:0] rs2_data;
    rf_wr_t      rf_wr;
    dmem_req_t   dmem_req;
    dmem_rsp_t   dmem_rsp;

    // Decode fields
    logic [31:0] ins;
    logic [6:0]  opcode;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] imm_i;
    logic [31:0] imm_s;
    logic [31:0] imm_b;
    logic [31:0] imm_j;
    logic        ex_run;
    logic        is_halt_word;

    logic [31:0] npc;
    logic        halt_n;
    logic [1:0]  cause;
    logic        wr;
    logic [31:0] res;
    logic [31:0] rword;
    logic        ex_we;
    out_item_t   ex_out;

    rvc_regfile u_regfile (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .rs1_addr(s_item.instruction[19:15]),
        .rs2_addr(s_item.instruction[24:20]),
        .wr      (rf_wr),
        .rs1_data(rs1_data),
        .rs2_data(rs2_data)
    );

    rvc_dmem #(
        .DMEM_BYTES(DMEM_BYTES)
    ) u_dmem (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (dmem_req),
        .rsp    (dmem_rsp)
    );

    // ---------------------------------------------------------------------------------------
    // Decode
    // ---------------------------------------------------------------------------------------
    assign ins    = dec_item_reg.instruction;
    assign opcode = ins[6:0];
    assign rd     = ins[11:7];
    assign f3     = ins[14:12];
    assign f7     = ins[31:25];
    assign imm_i  = {{20{ins[31]}}, ins[31:20]};
    assign imm_s  = {{20{ins[31]}}, ins[31:25], ins[11:7]};
    assign imm_b  = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
    assign imm_j  = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};

    // A halted core ignores execute items altogether
    assign ex_run       = (dec_item_reg.action == ACT_EXEC) && !halt_reg;
    assign is_halt_word = (ins == HALT_WORD);

    assign ex_is_mem = (dec_item_reg.action == ACT_PRELOAD) ||
                       (dec_item_reg.action == ACT_READ) ||
                       (ex_run && !is_halt_word && (opcode == OP_LOAD || opcode == OP_STORE));

    // ---------------------------------------------------------------------------------------
    // Data memory request: issue once per item, hold the response until the result leaves
    // ---------------------------------------------------------------------------------------
    assign dmem_req.valid = dec_valid_reg && ex_is_mem && !mem_issued_reg;
    assign dmem_req.write = (dec_item_reg.action == ACT_PRELOAD) ||
                            ((dec_item_reg.action == ACT_EXEC) && (opcode == OP_STORE));
    assign dmem_req.addr  = (dec_item_reg.action == ACT_EXEC) ?
                            rs1_data + ((opcode == OP_STORE) ? imm_s : imm_i) :
                            32'(dec_item_reg.mem_address);
    assign dmem_req.wdata = (dec_item_reg.action == ACT_EXEC) ? rs2_data : dec_item_reg.mem_word;

    assign mem_ok        = dmem_rsp.done || mem_fin_reg;
    assign mem_load_word = mem_fin_reg ? mem_rdata_reg : dmem_rsp.rdata;

    // ---------------------------------------------------------------------------------------
    // Execute
    // ---------------------------------------------------------------------------------------
    always_comb begin
        npc    = pc_reg;
        halt_n = halt_reg;
        cause  = CAUSE_NONE;
        wr     = 1'b0;
        res    = '0;
        rword  = '0;

        if (dec_item_reg.action == ACT_READ) begin
            rword = mem_load_word;
        end else if (ex_run) begin
            if (is_halt_word) begin
                halt_n = 1'b1;
                cause  = CAUSE_HALT_WORD;
            end else begin
                npc = pc_reg + 32'd4;
                unique case (opcode)
                    OP_R: begin
                        wr = 1'b1;
                        case (f3)
                            F3_ADD: begin
                                if (f7 == F7_BASE) begin
                                    res = rs1_data + rs2_data;
                                end else if (f7 == F7_ALT) begin
                                    res = rs1_data - rs2_data;
                                end
                            end
                            F3_AND:  res = rs1_data & rs2_data;
                            F3_OR:   res = rs1_data | rs2_data;
                            F3_XOR:  res = rs1_data ^ rs2_data;
                            default: begin
                                // Unknown R-type funct3: stop here, no write, PC held
                                wr     = 1'b0;
                                halt_n = 1'b1;
                                cause  = CAUSE_R_FUNCT3;
                                npc    = pc_reg;
                            end
                        endcase
                    end
                    OP_I: begin
                        wr = 1'b1;
                        case (f3)
                            F3_ADD:  res = rs1_data + imm_i;
                            F3_AND:  res = rs1_data & imm_i;
                            F3_OR:   res = rs1_data | imm_i;
                            F3_XOR:  res = rs1_data ^ imm_i;
                            default: res = '0;
                        endcase
                    end
                    OP_LOAD: begin
                        wr  = 1'b1;
                        res = mem_load_word;
                    end
                    OP_STORE: begin
                        wr = 1'b0;
                    end
                    OP_BRANCH: begin
                        if ((f3 == F3_BEQ && rs1_data == rs2_data) ||
                            (f3 == F3_BNE && rs1_data != rs2_data)) begin
                            npc = pc_reg + imm_b;
                        end
                    end
                    OP_JAL: begin
                        wr  = 1'b1;
                        res = pc_reg + 32'd4;
                        npc = pc_reg + imm_j;
                    end
                    default: begin
                        // Unknown opcode: the PC still advances
                        halt_n = 1'b1;
                        cause  = CAUSE_OPCODE;
                    end
                endcase
            end
        end
    end

    // Drop writes to x0
    assign ex_we = wr && (rd != 5'd0);

    always_comb begin
        ex_out.next_pc          = npc;
        ex_out.is_halted        = halt_n;
        ex_out.halt_cause       = cause;
        ex_out.reg_write_enable = ex_we;
        ex_out.reg_write_index  = ex_we ? rd : 5'd0;
        ex_out.reg_write_value  = ex_we ? res : '0;
        ex_out.read_word        = rword;
    end

    assign rf_wr.en   = ex_done && ex_we;
    assign rf_wr.addr = rd;
    assign rf_wr.data = res;

    // ---------------------------------------------------------------------------------------
    // Flow control: the item retires into the result register when that register is free or
    // being emptied in the same cycle, and its memory access (if any) has finished
    // ---------------------------------------------------------------------------------------
    assign out_free = !out_valid_reg || m_ready;
    assign ex_done  = dec_valid_reg && out_free && (!ex_is_mem || mem_ok);
    assign s_ready  = !dmem_rsp.clearing && (!dec_valid_reg || ex_done);
    assign accept   = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dec_valid_reg  <= 1'b0;
            mem_issued_reg <= 1'b0;
            mem_fin_reg    <= 1'b0;
            pc_reg         <= '0;
            halt_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            // Advance the execute slot
            if (accept) begin
                dec_valid_reg <= 1'b1;
            end else if (ex_done) begin
                dec_valid_reg <= 1'b0;
            end

            // Track the memory access of the item in the execute slot
            if (ex_done) begin
                mem_issued_reg <= 1'b0;
                mem_fin_reg    <= 1'b0;
            end else begin
                if (dmem_req.valid && dmem_rsp.ready) begin
                    mem_issued_reg <= 1'b1;
                end
                if (dmem_rsp.done) begin
                    mem_fin_reg <= 1'b1;
                end
            end

            // Commit PC and halt flag as the item retires
            if (ex_done) begin
                pc_reg   <= npc;
                halt_reg <= halt_n;
            end

            // Hold the result until its transfer completes
            if (ex_done) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            dec_item_reg <= s_item;
        end
        if (dmem_rsp.done) begin
            mem_rdata_reg <= dmem_rsp.rdata;
        end
        if (ex_done) begin
            out_item_reg <= ex_out;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

    // ---------------------------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------------------------

    // A memory request is only raised while the data memory sequencer can take it
    a_req_when_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        dmem_req.valid |-> dmem_rsp.ready)
        else $error("data memory request raised while the sequencer is busy");

    // A memory response only arrives for an access this item issued
    a_done_issued: assert property (@(posedge aclk) disable iff (!aresetn)
        dmem_rsp.done |-> mem_issued_reg)
        else $error("data memory response without an issued request");

    // Once halted the program counter no longer moves
    a_halt_pc: assert property (@(posedge aclk) disable iff (!aresetn)
        halt_reg |=> $stable(pc_reg))
        else $error("program counter moved while halted");

    // x0 is never reported as written
    a_no_x0_write: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_item.reg_write_enable && m_item.reg_write_index == 5'd0))
        else $error("write to x0 reported");

endmodule

>>> design/rvc_regfile.sv
module rvc_regfile
    import rvc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        rd_en,
    input  logic [4:0]  rs1_addr,
    input  logic [4:0]  rs2_addr,
    input  rf_wr_t      wr,
    output logic [31:0] rs1_data,
    output logic [31:0] rs2_data
);

    logic [31:0] ram_reg [32];
    logic [31:0] valid_reg;
    logic [31:0] rs1_data_reg;
    logic [31:0] rs2_data_reg;

    // Entries never written read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr.en) begin
            valid_reg[wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            ram_reg[wr.addr] <= wr.data;
        end
    end

    // Synchronous read, write-first on a same-entry collision
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (wr.en && wr.addr == rs1_addr) begin
                rs1_data_reg <= wr.data;
            end else begin
                rs1_data_reg <= valid_reg[rs1_addr] ? ram_reg[rs1_addr] : '0;
            end
            if (wr.en && wr.addr == rs2_addr) begin
                rs2_data_reg <= wr.data;
            end else begin
                rs2_data_reg <= valid_reg[rs2_addr] ? ram_reg[rs2_addr] : '0;
            end
        end
    end

    assign rs1_data = rs1_data_reg;
    assign rs2_data = rs2_data_reg;

endmodule

>>> design/rvc_addr_mod.sv
module rvc_addr_mod
    import rvc_pkg::*;
#(
    parameter int unsigned DMEM_BYTES = DMEM_BYTES_DEF
)
(
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [31:0]                   x,
    output logic                          done,
    output logic [$clog2(DMEM_BYTES)-1:0] r
);

    localparam int unsigned AW = $clog2(DMEM_BYTES);
    localparam bit IS_POW2 = (DMEM_BYTES & (DMEM_BYTES - 1)) == 0;

    generate
        if (IS_POW2) begin : g_mask
            logic          done_reg;
            logic [AW-1:0] r_reg;

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    done_reg <= 1'b0;
                end else begin
                    done_reg <= start;
                end
            end

            always_ff @(posedge aclk) begin
                if (start) begin
                    r_reg <= x[AW-1:0];
                end
            end

            assign done = done_reg;
            assign r    = r_reg;
        end else begin : g_digit
            // Reduce one hex digit per cycle: r = (r * 16 + digit) mod N
            localparam int unsigned DIGIT_W = 4;
            localparam int unsigned RADIX   = 1 << DIGIT_W;
            localparam int unsigned DIGITS  = 32 / DIGIT_W;
            localparam int unsigned CW      = $clog2(DIGITS);
            localparam int unsigned TW      = AW + DIGIT_W;

            logic          busy_reg;
            logic          done_reg;
            logic [CW-1:0] cnt_reg;
            logic [31:0]   x_reg;
            logic [AW-1:0] r_reg;
            logic [TW-1:0] t;
            logic [TW-1:0] sub_val;
            logic [TW-1:0] rem;

            always_comb begin
                t       = {r_reg, x_reg[31 -: DIGIT_W]};
                sub_val = '0;
                for (int k = 1; k < RADIX; k++) begin
                    if (t >= TW'(k * DMEM_BYTES)) begin
                        sub_val = TW'(k * DMEM_BYTES);
                    end
                end
                rem = t - sub_val;
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b0;
                    cnt_reg  <= '0;
                end else begin
                    done_reg <= 1'b0;
                    if (start) begin
                        busy_reg <= 1'b1;
                        cnt_reg  <= '0;
                    end else if (busy_reg) begin
                        cnt_reg <= cnt_reg + 1'b1;
                        if (cnt_reg == CW'(DIGITS - 1)) begin
                            busy_reg <= 1'b0;
                            done_reg <= 1'b1;
                        end
                    end
                end
            end

            always_ff @(posedge aclk) begin
                if (start) begin
                    x_reg <= x;
                    r_reg <= '0;
                end else if (busy_reg) begin
                    x_reg <= {x_reg[31-DIGIT_W:0], {DIGIT_W{1'b0}}};
                    r_reg <= rem[AW-1:0];
                end
            end

            assign done = done_reg;
            assign r    = r_reg;
        end
    endgenerate

endmodule

>>> design/rvc_dmem.sv
module rvc_dmem
    import rvc_pkg::*;
#(
    parameter int unsigned DMEM_BYTES = DMEM_BYTES_DEF
)
(
    input  logic      aclk,
    input  logic      aresetn,
    input  dmem_req_t req,
    output dmem_rsp_t rsp
);

    localparam int unsigned AW = $clog2(DMEM_BYTES);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MOD   = 3'd1;
    localparam logic [2:0] ST_ACC   = 3'd2;
    localparam logic [2:0] ST_LAST  = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;
    localparam logic [2:0] ST_CLEAR = 3'd5;

    logic [2:0]    state_reg;
    logic [2:0]    state_next;
    logic [AW-1:0] addr_reg;
    logic [AW-1:0] addr_inc;
    logic [1:0]    cnt_reg;
    logic          write_reg;
    logic          rd_pend_reg;
    logic [31:0]   wdata_reg;
    logic [31:0]   word_reg;
    logic [7:0]    q_reg;
    logic [7:0]    ram_reg [DMEM_BYTES];

    logic          mod_start;
    logic          mod_done;
    logic [AW-1:0] mod_r;

    logic          mem_we;
    logic [7:0]    mem_wdata;

    rvc_addr_mod #(
        .DMEM_BYTES(DMEM_BYTES)
    ) u_addr_mod (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (mod_start),
        .x      (req.addr),
        .done   (mod_done),
        .r      (mod_r)
    );

    assign mod_start = (state_reg == ST_IDLE) && req.valid;
    // Bytes of a word wrap at the end of memory
    assign addr_inc  = (addr_reg == AW'(DMEM_BYTES - 1)) ? '0 : addr_reg + 1'b1;
    assign mem_we    = (state_reg == ST_CLEAR) || ((state_reg == ST_ACC) && write_reg);
    assign mem_wdata = (state_reg == ST_CLEAR) ? 8'h00 : wdata_reg[31:24];

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (req.valid) state_next = ST_MOD;
            ST_MOD:   if (mod_done) state_next = ST_ACC;
            ST_ACC:   if (cnt_reg == 2'd3) state_next = write_reg ? ST_DONE : ST_LAST;
            ST_LAST:  state_next = ST_DONE;
            ST_DONE:  state_next = ST_IDLE;
            ST_CLEAR: if (addr_reg == AW'(DMEM_BYTES - 1)) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            addr_reg    <= '0;
            cnt_reg     <= '0;
            rd_pend_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_pend_reg <= (state_reg == ST_ACC) && !write_reg;
            if (state_reg == ST_MOD && mod_done) begin
                addr_reg <= mod_r;
                cnt_reg  <= '0;
            end else if (state_reg == ST_ACC) begin
                addr_reg <= addr_inc;
                cnt_reg  <= cnt_reg + 1'b1;
            end else if (state_reg == ST_CLEAR) begin
                addr_reg <= addr_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mod_start) begin
            write_reg <= req.write;
            wdata_reg <= req.wdata;
        end else if (state_reg == ST_ACC) begin
            wdata_reg <= {wdata_reg[23:0], 8'h00};
        end
        if (rd_pend_reg) begin
            word_reg <= {word_reg[23:0], q_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            ram_reg[addr_reg] <= mem_wdata;
        end
        q_reg <= ram_reg[addr_reg];
    end

    assign rsp.ready    = (state_reg == ST_IDLE);
    assign rsp.done     = (state_reg == ST_DONE);
    assign rsp.clearing = (state_reg == ST_CLEAR);
    assign rsp.rdata    = word_reg;

endmodule

>>> dv/testbench.sv
module testbench;
    import rvc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DMEM_BYTES = DMEM_BYTES_DEF;

    // The package names three actions; the fourth code is taken but does nothing
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // Allow for the memory sweep after reset plus every item at its slowest
    // (longest sender gap, slowest memory walk, longest result stall), many times over
    localparam int unsigned RUN_LIMIT_NS = 600_000;

    // Cycles to keep watching the result side once nothing is outstanding
    localparam int unsigned DRAIN_CYCLES = 32;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    // When clear, both sides run flat out with no idle cycles
    bit idle_on = 1'b1;

    int unsigned err_count = 0;

    // Results predicted at each accepted input transfer, oldest first
    out_item_t pending_results[$];

    // Predictor state: program counter, halt flag, register file, byte memory
    logic [31:0] core_pc;
    logic        core_halted;
    logic [31:0] gpr [32];
    logic [7:0]  dmem [DMEM_BYTES];

    rv32i_subset_single_cycle_core #(
        .DMEM_BYTES (DMEM_BYTES)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    // 2 ns clock: high for one, low for one
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Instruction encoders
    // ------------------------------------------------------------------

    function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3, logic [4:0] rd);
        return {f7, rs2, rs1, f3, rd, OP_R};
    endfunction

    function automatic logic [31:0] enc_i(logic [6:0] op, logic [4:0] rd, logic [2:0] f3,
                                          logic [4:0] rs1, logic [11:0] imm);
        return {imm, rs1, f3, rd, op};
    endfunction

    function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1);
        return {imm[11:5], rs2, rs1, 3'd2, imm[4:0], OP_STORE};
    endfunction

    function automatic logic [31:0] enc_b(logic [2:0] f3, logic [4:0] rs1, logic [4:0] rs2,
                                          logic [12:0] imm);
        return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OP_BRANCH};
    endfunction

    function automatic logic [31:0] enc_j(logic [4:0] rd, logic [20:0] imm);
        return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OP_JAL};
    endfunction

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Big-endian word, every byte address wrapped on its own
    function automatic logic [31:0] dmem_load(logic [31:0] addr);
        logic [31:0] v;
        v = '0;
        for (int i = 0; i < 4; i++)
            v = {v[23:0], dmem[(64'(addr) + i) % DMEM_BYTES]};
        return v;
    endfunction

    function automatic void dmem_store(logic [31:0] addr, logic [31:0] v);
        for (int i = 0; i < 4; i++)
            dmem[(64'(addr) + i) % DMEM_BYTES] = v[8 * (3 - i) +: 8];
    endfunction

    // Apply one input item to the predictor state and return the result it should cause
    function automatic out_item_t step_core(in_item_t it);
        out_item_t   r;
        logic [31:0] ins;
        logic [6:0]  opc;
        logic [4:0]  rd;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] imm_i;
        logic [31:0] imm_s;
        logic [31:0] imm_b;
        logic [31:0] imm_j;
        logic [31:0] npc;
        logic [31:0] res;
        logic        wr;

        r     = '0;
        ins   = it.instruction;
        opc   = ins[6:0];
        rd    = ins[11:7];
        f3    = ins[14:12];
        f7    = ins[31:25];
        a     = gpr[ins[19:15]];
        b     = gpr[ins[24:20]];
        imm_i = {{20{ins[31]}}, ins[31:20]};
        imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
        imm_b = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
        imm_j = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};

        case (it.action)
            ACT_PRELOAD: dmem_store(32'(it.mem_address), it.mem_word);
            ACT_READ:    r.read_word = dmem_load(32'(it.mem_address));
            ACT_EXEC: begin
                if (!core_halted) begin
                    if (ins == HALT_WORD) begin
                        core_halted  = 1'b1;
                        r.halt_cause = CAUSE_HALT_WORD;
                    end else begin
                        npc = core_pc + 32'd4;
                        res = '0;
                        wr  = 1'b0;
                        case (opc)
                            OP_R: begin
                                wr = 1'b1;
                                case (f3)
                                    F3_ADD: begin
                                        if (f7 == F7_BASE)
                                            res = a + b;
                                        else if (f7 == F7_ALT)
                                            res = a - b;
                                    end
                                    F3_AND: res = a & b;
                                    F3_OR:  res = a | b;
                                    F3_XOR: res = a ^ b;
                                    default: begin
                                        wr           = 1'b0;
                                        core_halted  = 1'b1;
                                        r.halt_cause = CAUSE_R_FUNCT3;
                                        npc          = core_pc;
                                    end
                                endcase
                            end
                            OP_I: begin
                                wr = 1'b1;
                                case (f3)
                                    F3_ADD:  res = a + imm_i;
                                    F3_AND:  res = a & imm_i;
                                    F3_OR:   res = a | imm_i;
                                    F3_XOR:  res = a ^ imm_i;
                                    default: res = '0;
                                endcase
                            end
                            OP_LOAD: begin
                                wr  = 1'b1;
                                res = dmem_load(a + imm_i);
                            end
                            OP_STORE: dmem_store(a + imm_s, b);
                            OP_BRANCH: begin
                                if ((f3 == F3_BEQ && a == b) || (f3 == F3_BNE && a != b))
                                    npc = core_pc + imm_b;
                            end
                            OP_JAL: begin
                                wr  = 1'b1;
                                res = core_pc + 32'd4;
                                npc = core_pc + imm_j;
                            end
                            default: begin
                                core_halted  = 1'b1;
                                r.halt_cause = CAUSE_OPCODE;
                            end
                        endcase
                        if (wr && rd != 5'd0) begin
                            gpr[rd]            = res;
                            r.reg_write_enable = 1'b1;
                            r.reg_write_index  = rd;
                            r.reg_write_value  = res;
                        end
                        core_pc = npc;
                    end
                end
            end
            default: ;
        endcase

        r.next_pc   = core_pc;
        r.is_halted = core_halted;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Reporting and result checking
    // ------------------------------------------------------------------

    function automatic void note_failure(string msg);
        err_count++;
        if (err_count <= 10)
            $display("%0t: %s", $realtime, msg);
    endfunction

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
            note_failure($sformatf("%s mismatch: expected %h, got %h", name, want, got));
    endfunction

    // Result side: draw a stall per result, take one transfer, then check it against the
    // oldest prediction. A zero stall keeps ready high straight into the next transfer.
    always begin : result_side
        int unsigned stall;
        out_item_t   want;
        stall = idle_on ? $urandom_range(0, 7) : 0;
        if (stall != 0) begin
            m_ready <= 1'b0;
            repeat (stall) @(negedge aclk);
        end
        m_ready <= 1'b1;
        do @(posedge aclk); while (!(m_valid === 1'b1 && m_ready === 1'b1));
        if (pending_results.size() == 0) begin
            note_failure($sformatf("result transfer with nothing outstanding: %h", m_item));
        end else begin
            want = pending_results.pop_front();
            compare_field("next_pc", want.next_pc, m_item.next_pc);
            compare_field("is_halted", 32'(want.is_halted), 32'(m_item.is_halted));
            compare_field("halt_cause", 32'(want.halt_cause), 32'(m_item.halt_cause));
            compare_field("reg_write_enable", 32'(want.reg_write_enable),
                          32'(m_item.reg_write_enable));
            compare_field("reg_write_index", 32'(want.reg_write_index),
                          32'(m_item.reg_write_index));
            compare_field("reg_write_value", want.reg_write_value, m_item.reg_write_value);
            compare_field("read_word", want.read_word, m_item.read_word);
        end
        @(negedge aclk);
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Entered and left at a falling edge. Hold valid and payload until the transfer,
    // then predict its result. With a zero gap valid simply stays high.
    task automatic send_item(in_item_t it);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, 7) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_item  <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (s_ready !== 1'b1);
        pending_results.push_back(step_core(it));
        @(negedge aclk);
    endtask

    // Execute item; the memory fields are don't-care, so fill them with noise
    task automatic send_exec(logic [31:0] ins);
        in_item_t it;
        it.action      = ACT_EXEC;
        it.instruction = ins;
        it.mem_address = 10'($urandom);
        it.mem_word    = $urandom;
        send_item(it);
    endtask

    task automatic send_mem(logic [1:0] action, logic [9:0] addr, logic [31:0] word);
        in_item_t it;
        it.action      = action;
        it.instruction = $urandom;
        it.mem_address = addr;
        it.mem_word    = word;
        send_item(it);
    endtask

    // ------------------------------------------------------------------
    // Random picks
    // ------------------------------------------------------------------

    // Half the time a low register, so that operands often match and branches go both ways
    function automatic logic [4:0] pick_reg();
        return ($urandom_range(0, 1) == 0) ? 5'($urandom_range(0, 3)) : 5'($urandom);
    endfunction

    function automatic logic [2:0] pick_r_funct3();
        case ($urandom_range(0, 3))
            0:       return F3_ADD;
            1:       return F3_XOR;
            2:       return F3_OR;
            default: return F3_AND;
        endcase
    endfunction

    function automatic logic [6:0] pick_opcode();
        case ($urandom_range(0, 5))
            0:       return OP_R;
            1:       return OP_I;
            2:       return OP_LOAD;
            3:       return OP_STORE;
            4:       return OP_BRANCH;
            default: return OP_JAL;
        endcase
    endfunction

    // Byte address biased towards the bottom of memory and the wrap point
    function automatic logic [9:0] pick_addr();
        case ($urandom_range(0, 2))
            0:       return 10'($urandom);
            1:       return 10'($urandom_range(0, 31));
            default: return 10'($urandom_range(DMEM_BYTES - 4, DMEM_BYTES - 1));
        endcase
    endfunction

    // Offset off x0 that lands near the start of memory or just behind it
    function automatic logic [11:0] pick_near_offset();
        if ($urandom_range(0, 1) == 0)
            return 12'($urandom_range(0, 40));
        return 12'(4096 - $urandom_range(1, 8));
    endfunction

    // Any instruction that keeps the core running: known opcodes only, R-type with a
    // listed funct3, random content elsewhere
    function automatic logic [31:0] random_insn();
        logic [31:0] w;
        logic [6:0]  f7;
        f7 = ($urandom_range(0, 3) == 0) ? 7'($urandom) :
             ($urandom_range(0, 1) == 0) ? F7_BASE : F7_ALT;
        case ($urandom_range(0, 9))
            0, 1: w = enc_r(f7, pick_reg(), pick_reg(), pick_r_funct3(), 5'($urandom));
            2, 3: w = enc_i(OP_I, 5'($urandom), 3'($urandom), pick_reg(), 12'($urandom));
            4: begin
                if ($urandom_range(0, 1) == 0)
                    w = enc_i(OP_LOAD, 5'($urandom), 3'($urandom), 5'd0, pick_near_offset());
                else
                    w = enc_i(OP_LOAD, 5'($urandom), 3'($urandom), pick_reg(), 12'($urandom));
            end
            5: begin
                if ($urandom_range(0, 1) == 0)
                    w = enc_s(pick_near_offset(), pick_reg(), 5'd0);
                else
                    w = enc_s(12'($urandom), pick_reg(), pick_reg());
            end
            6, 7: w = enc_b(($urandom_range(0, 3) == 0) ? 3'($urandom) :
                            ($urandom_range(0, 1) == 0) ? F3_BEQ : F3_BNE,
                            pick_reg(), pick_reg(), 13'($urandom));
            8: w = enc_j(5'($urandom), 21'($urandom));
            default: begin
                // Raw word under a known opcode; keep R-type away from the halting funct3s
                w      = $urandom;
                w[6:0] = pick_opcode();
                if (w[6:0] == OP_R)
                    w[14:12] = pick_r_funct3();
            end
        endcase
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Preload and readback, including a word that wraps past the last byte,
    // a read of untouched memory and the unused action code
    task automatic test_memory_actions();
        send_mem(ACT_READ, 10'd512, '0);
        send_mem(ACT_PRELOAD, 10'd0, 32'hFFFF_FFFF);
        send_mem(ACT_READ, 10'd0, '0);
        send_mem(ACT_PRELOAD, 10'h3FF, 32'h0123_4567);
        send_mem(ACT_READ, 10'h3FE, '0);
        send_mem(ACT_READ, 10'h3FF, '0);
        send_mem(ACT_READ, 10'd0, '0);
        send_item('1);
        send_mem(ACT_PRELOAD, 10'h3FF, 32'h0000_0000);
        send_mem(ACT_READ, 10'h3FD, '0);
    endtask

    // Register and immediate arithmetic at the immediate extremes, the unlisted
    // funct7 and I-type funct3 cases, and writes aimed at x0
    task automatic test_alu_ops();
        send_exec(enc_i(OP_I, 5'd1, F3_ADD, 5'd0, 12'h7FF));
        send_exec(enc_i(OP_I, 5'd2, F3_ADD, 5'd0, 12'h800));
        send_exec(enc_i(OP_I, 5'd3, F3_XOR, 5'd0, 12'hFFF));
        send_exec(enc_i(OP_I, 5'd4, F3_OR, 5'd1, 12'h800));
        send_exec(enc_i(OP_I, 5'd5, F3_AND, 5'd3, 12'h555));
        send_exec(enc_i(OP_I, 5'd6, 3'd2, 5'd3, 12'h123));
        send_exec(enc_i(OP_I, 5'd0, F3_ADD, 5'd1, 12'h001));
        send_exec(enc_r(F7_BASE, 5'd2, 5'd1, F3_ADD, 5'd7));
        send_exec(enc_r(F7_ALT, 5'd3, 5'd0, F3_ADD, 5'd8));
        send_exec(enc_r(7'h01, 5'd1, 5'd1, F3_ADD, 5'd9));
        send_exec(enc_r(F7_BASE, 5'd3, 5'd1, F3_AND, 5'd10));
        send_exec(enc_r(7'h7F, 5'd2, 5'd1, F3_OR, 5'd11));
        send_exec(enc_r(F7_ALT, 5'd3, 5'd1, F3_XOR, 5'd12));
        send_exec(enc_r(F7_BASE, 5'd3, 5'd3, F3_ADD, 5'd31));
        send_exec(enc_r(F7_BASE, 5'd1, 5'd1, F3_ADD, 5'd0));
    endtask

    // Stores and loads that straddle the end of memory, and a load into x0
    task automatic test_load_store();
        send_exec(enc_s(12'hFFE, 5'd12, 5'd0));
        send_mem(ACT_READ, 10'h3FE, '0);
        send_exec(enc_i(OP_LOAD, 5'd13, 3'd2, 5'd0, 12'hFFE));
        send_exec(enc_s(12'h7FF, 5'd8, 5'd2));
        send_exec(enc_i(OP_LOAD, 5'd14, 3'd2, 5'd2, 12'h7FF));
        send_exec(enc_i(OP_LOAD, 5'd0, 3'd2, 5'd0, 12'h000));
    endtask

    // Branches taken and not, a funct3 that never branches, offset extremes, and jumps
    task automatic test_control_flow();
        send_exec(enc_b(F3_BEQ, 5'd0, 5'd0, 13'h0008));
        send_exec(enc_b(F3_BEQ, 5'd1, 5'd2, 13'h0010));
        send_exec(enc_b(F3_BNE, 5'd1, 5'd2, 13'h1FFC));
        send_exec(enc_b(F3_BNE, 5'd3, 5'd4, 13'h0FFE));
        send_exec(enc_b(3'd4, 5'd0, 5'd0, 13'h0008));
        send_exec(enc_b(F3_BEQ, 5'd3, 5'd4, 13'h0FFE));
        send_exec(enc_b(F3_BNE, 5'd1, 5'd0, 13'h1000));
        send_exec(enc_j(5'd1, 21'h0F_FFFE));
        send_exec(enc_j(5'd15, 21'h10_0000));
        send_exec(enc_j(5'd0, 21'h00_0008));
    endtask

    // Long stream of running-core instructions mixed with memory traffic and the
    // unused action; idling drops out for one stretch in every 250 items
    task automatic test_random_program();
        in_item_t it;
        for (int n = 0; n < 1000; n++) begin
            idle_on = (n % 250) < 190;
            case ($urandom_range(0, 19))
                0, 1: send_mem(ACT_PRELOAD, pick_addr(), $urandom);
                2, 3: send_mem(ACT_READ, pick_addr(), $urandom);
                4: begin
                    it             = in_item_t'({$urandom, $urandom, $urandom});
                    it.action      = ACT_UNUSED;
                    send_item(it);
                end
                default: send_exec(random_insn());
            endcase
        end
        idle_on = 1'b1;
    endtask

    // Halting is sticky for the rest of the run, so only one cause can be raised per
    // run: draw which. Then show that execute items are ignored while memory actions
    // still work.
    task automatic test_halt_and_after();
        logic [31:0] w;
        in_item_t    it;
        case ($urandom_range(0, 2))
            0: send_exec(HALT_WORD);
            1: begin
                do begin
                    w = $urandom;
                end while (w[6:0] inside {OP_R, OP_I, OP_LOAD, OP_STORE, OP_BRANCH, OP_JAL}
                           || w == HALT_WORD);
                send_exec(w);
            end
            default: begin
                w        = enc_r(7'($urandom), pick_reg(), pick_reg(), 3'd1, 5'($urandom));
                w[14:12] = ($urandom_range(0, 1) == 0) ? 3'($urandom_range(1, 3)) : 3'd5;
                send_exec(w);
            end
        endcase
        send_exec(HALT_WORD);
        for (int n = 0; n < 80; n++) begin
            it = in_item_t'({$urandom, $urandom, $urandom});
            if (it.action == ACT_EXEC && $urandom_range(0, 1) == 0)
                it.instruction = random_insn();
            send_item(it);
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        core_pc     = '0;
        core_halted = 1'b0;
        for (int i = 0; i < 32; i++)
            gpr[i] = '0;
        for (int i = 0; i < DMEM_BYTES; i++)
            dmem[i] = '0;

        // Hold reset, then release it at a falling edge
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_memory_actions();
        test_alu_ops();
        test_load_store();
        test_control_flow();
        test_random_program();
        test_halt_and_after();

        // Drop valid, wait for every outstanding result, then watch for strays
        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (err_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    // Watchdog
    initial begin
        #RUN_LIMIT_NS;
        $display("testbench NOT OK");
        $finish;
    end

endmodule
